@@ hdl/mkde_pkg.sv @@
`timescale 1ns / 1ps

package mkde_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_CHANNEL_COUNT  = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE_MS    = 2'd1;
   localparam logic [1:0] CSR_KEY_CODE_TABLE = 2'd2;
   localparam logic [1:0] CSR_PIN_TABLE      = 2'd3;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd25;

   // One sampled key line
   typedef struct packed {
      logic [2:0]  channel;
      logic        level;
      logic        read_failed;
      logic [31:0] time_ms;
      logic        prime;
   } sample_type;

   // Configuration seen by the tracker
   typedef struct packed {
      logic [3:0]  channel_count;
      logic [7:0]  debounce_ms;
      logic [63:0] key_code_table;
      logic [47:0] pin_table;
   } cfg_type;

   // One result
   typedef struct packed {
      logic        event_valid;
      logic        pressed;
      logic [7:0]  key_code;
      logic [6:0]  pin_code;
      logic [31:0] press_total;
      logic [31:0] read_error_total;
   } result_type;

endpackage

@@ hdl/mkde_track.sv @@
`timescale 1ns / 1ps

module mkde_track
   import mkde_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  sample_type sample,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [3:0] CH_MAX = 4'(CHANNELS);

   // Per-channel state and running counters
   logic [CHANNELS-1:0] raw_ff, raw_in;
   logic [CHANNELS-1:0] stable_ff, stable_in;
   logic [31:0]         change_time_ff [CHANNELS];
   logic [31:0]         change_time_in [CHANNELS];
   logic [31:0]         press_ff, press_in;
   logic [31:0]         error_ff, error_in;

   logic [3:0]      limit;
   logic            in_use;
   logic [CH_W-1:0] idx;
   logic            now_pressed;
   logic [31:0]     elapsed;
   logic            held;
   logic            take;

   assign limit       = (cfg.channel_count > CH_MAX) ? CH_MAX : cfg.channel_count;
   assign in_use      = ({1'b0, sample.channel} < limit);
   assign idx         = sample.channel[CH_W-1:0];
   assign now_pressed = ~sample.level;
   assign elapsed     = sample.time_ms - change_time_ff[idx];
   assign held        = (elapsed >= {24'd0, cfg.debounce_ms});

   // Decision for this sample
   always_comb begin
      raw_in         = raw_ff;
      stable_in      = stable_ff;
      change_time_in = change_time_ff;
      press_in       = press_ff;
      error_in       = error_ff;
      take           = 1'b0;
      if (in_use) begin
         priority if (sample.read_failed) begin
            error_in = error_ff + 32'd1;
         end else if (sample.prime) begin
            raw_in[idx]    = now_pressed;
            stable_in[idx] = now_pressed;
         end else if (now_pressed != raw_ff[idx]) begin
            raw_in[idx]         = now_pressed;
            change_time_in[idx] = sample.time_ms;
         end else if (now_pressed != stable_ff[idx] && held) begin
            stable_in[idx] = now_pressed;
            take           = 1'b1;
            if (now_pressed) begin
               press_in = press_ff + 32'd1;
            end
         end
      end
   end

   // Result fields; codes are zero when nothing is reported
   always_comb begin
      result.event_valid      = take;
      result.pressed          = take & now_pressed;
      result.key_code         = take ? cfg.key_code_table[8*sample.channel +: 8] : 8'd0;
      result.pin_code         = take ? ({1'b0, cfg.pin_table[6*sample.channel +: 6]} + 7'd1)
                                     : 7'd0;
      result.press_total      = press_in;
      result.read_error_total = error_in;
   end

   // State update when the request moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= '0;
         stable_ff <= '0;
         press_ff  <= '0;
         error_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            change_time_ff[i] <= '0;
         end
      end else if (advance) begin
         raw_ff         <= raw_in;
         stable_ff      <= stable_in;
         press_ff       <= press_in;
         error_ff       <= error_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

@@ hdl/multi_key_debounce_event_core.sv @@
`timescale 1ns / 1ps

// Multi-channel debouncer for active-low key lines.
// Request channel (req_*): one sampled line per request, with channel,
// level (0 = pressed), read-failure flag, millisecond time and prime flag.
// Response channel (rsp_*): exactly one response per request, carrying the
// debounced press/release event (if any) with key code and pin+1, plus the
// running press and read-error totals.
// Both channels handshake with valid/stall; a transfer happens on a rising
// edge with valid high and stall low.
// A request is held in the input register once accepted; the per-channel state
// update is made and its result moves into the response register, raising
// rsp_valid, when that register is free (rsp_valid low or rsp_stall low).
// Throughput: one request per cycle while rsp_stall is low; the per-channel
// read-modify-write of the state is done from the registered state as each request
// advances, so consecutive requests can hit the same channel back to back.
// When rsp_stall is held, the response register and input register fill and
// req_stall rises; nothing is lost.
// csr_* writes registers (channel count, debounce time, key code table, pin
// table); write them only while no request is in flight.
// Reset: synchronous, active high; clears all key state and counters, sets
// channel count to 0 (all samples ignored) and debounce time to 25 ms.
module multi_key_debounce_event_core
   import mkde_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   // requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_channel,
   input  logic        req_level,
   input  logic        req_read_failed,
   input  logic [31:0] req_time_ms,
   input  logic        req_prime,
   // responses
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_valid,
   output logic        rsp_pressed,
   output logic [7:0]  rsp_key_code,
   output logic [6:0]  rsp_pin_code,
   output logic [31:0] rsp_press_total,
   output logic [31:0] rsp_read_error_total
);

   cfg_type    cfg_ff;
   sample_type sample_ff;
   logic       sample_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count  <= '0;
         cfg_ff.debounce_ms    <= DEBOUNCE_RESET;
         cfg_ff.key_code_table <= '0;
         cfg_ff.pin_table      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT:  cfg_ff.channel_count  <= csr_wdata[3:0];
            CSR_DEBOUNCE_MS:    cfg_ff.debounce_ms    <= csr_wdata[7:0];
            CSR_KEY_CODE_TABLE: cfg_ff.key_code_table <= csr_wdata;
            CSR_PIN_TABLE:      cfg_ff.pin_table      <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   // Flow control
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = sample_valid_ff & out_free;
   assign req_stall = sample_valid_ff & ~out_free;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         sample_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         sample_ff.channel     <= req_channel;
         sample_ff.level       <= req_level;
         sample_ff.read_failed <= req_read_failed;
         sample_ff.time_ms     <= req_time_ms;
         sample_ff.prime       <= req_prime;
      end
   end

   mkde_track #(
      .CHANNELS(CHANNELS)
   ) u_track (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .sample (sample_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= sample_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_valid      = rsp_ff.event_valid;
   assign rsp_pressed          = rsp_ff.pressed;
   assign rsp_key_code         = rsp_ff.key_code;
   assign rsp_pin_code         = rsp_ff.pin_code;
   assign rsp_press_total      = rsp_ff.press_total;
   assign rsp_read_error_total = rsp_ff.read_error_total;

endmodule

@@ tb/sv/multi_key_debounce_event_core_tb.sv @@
`timescale 1ns / 1ps

module multi_key_debounce_event_core_tb;
   import mkde_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_PRINTS   = 40;
   localparam int KEY_CHANNELS = 8;

   // DUT ports, all inputs driven from time zero
   logic        clock;
   logic        reset            = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = CSR_CHANNEL_COUNT;
   logic [63:0] csr_wdata        = '0;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [2:0]  req_channel      = '0;
   logic        req_level        = 1'b1;
   logic        req_read_failed  = 1'b0;
   logic [31:0] req_time_ms      = '0;
   logic        req_prime        = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_event_valid;
   logic        rsp_pressed;
   logic [7:0]  rsp_key_code;
   logic [6:0]  rsp_pin_code;
   logic [31:0] rsp_press_total;
   logic [31:0] rsp_read_error_total;

   // Predicted key state and configuration
   cfg_type     key_cfg          = '{4'd0, DEBOUNCE_RESET, 64'd0, 48'd0};
   logic [7:0]  key_raw          = '0;
   logic [7:0]  key_stable       = '0;
   logic [31:0] key_change_ms [KEY_CHANNELS] = '{default: '0};
   logic [31:0] press_count      = '0;
   logic [31:0] read_error_count = '0;

   // Responses still owed by the block, oldest first
   result_type  pending_results[$];

   int          error_count      = 0;
   int          request_count    = 0;
   int          response_count   = 0;
   int          event_count      = 0;
   int          setting_count    = 0;
   int          cycle_count      = 0;
   bit          req_idle_enable  = 1'b1;
   bit          rsp_idle_enable  = 1'b1;
   int          hold_start       = 0;
   int          hold_len         = 0;
   logic [31:0] now_ms           = '0;
   logic [7:0]  key_target       = 8'hFF;

   multi_key_debounce_event_core #(
      .CHANNELS(KEY_CHANNELS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_channel         (req_channel),
      .req_level           (req_level),
      .req_read_failed     (req_read_failed),
      .req_time_ms         (req_time_ms),
      .req_prime           (req_prime),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_valid     (rsp_event_valid),
      .rsp_pressed         (rsp_pressed),
      .rsp_key_code        (rsp_key_code),
      .rsp_pin_code        (rsp_pin_code),
      .rsp_press_total     (rsp_press_total),
      .rsp_read_error_total(rsp_read_error_total)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Cycle count and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (cycle_count - hold_start < hold_len) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_idle_enable && ($urandom_range(0, 99) < 8);
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("response %0d %s: got %0h, expected %0h",
                                response_count, name, got, want));
      end
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         got = {rsp_event_valid, rsp_pressed, rsp_key_code, rsp_pin_code,
                rsp_press_total, rsp_read_error_total};
         if (pending_results.size() == 0) begin
            report_error("response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (want.event_valid) event_count++;
            check_field("event_valid", 32'(got.event_valid), 32'(want.event_valid));
            check_field("pressed", 32'(got.pressed), 32'(want.pressed));
            check_field("key_code", 32'(got.key_code), 32'(want.key_code));
            check_field("pin_code", 32'(got.pin_code), 32'(want.pin_code));
            check_field("press_total", got.press_total, want.press_total);
            check_field("read_error_total", got.read_error_total,
                        want.read_error_total);
         end
      end
   end

   // Debounce step: updates the predicted state, returns the response
   function automatic result_type debounce_step(input sample_type s);
      result_type  r;
      int unsigned active;
      logic        now_pressed;
      logic [31:0] elapsed;
      r = '0;
      active = (key_cfg.channel_count > KEY_CHANNELS) ? KEY_CHANNELS
                                                       : key_cfg.channel_count;
      now_pressed = ~s.level;
      elapsed = s.time_ms - key_change_ms[s.channel];
      if (s.channel < active) begin
         if (s.read_failed) begin
            read_error_count = read_error_count + 1;
         end else if (s.prime) begin
            key_raw[s.channel] = now_pressed;
            key_stable[s.channel] = now_pressed;
         end else if (now_pressed != key_raw[s.channel]) begin
            key_raw[s.channel] = now_pressed;
            key_change_ms[s.channel] = s.time_ms;
         end else if (now_pressed != key_stable[s.channel] &&
                      elapsed >= {24'd0, key_cfg.debounce_ms}) begin
            key_stable[s.channel] = now_pressed;
            r.event_valid = 1'b1;
            r.pressed = now_pressed;
            r.key_code = key_cfg.key_code_table[8 * s.channel +: 8];
            r.pin_code = {1'b0, key_cfg.pin_table[6 * s.channel +: 6]} + 7'd1;
            if (now_pressed) press_count = press_count + 1;
         end
      end
      r.press_total = press_count;
      r.read_error_total = read_error_count;
      return r;
   endfunction

   // Offer one request; predict its response once accepted
   task automatic send_sample(input logic [2:0] channel, input logic level,
                              input logic failed, input logic [31:0] time_ms,
                              input logic prime);
      sample_type s;
      s = '{channel, level, failed, time_ms, prime};
      @(negedge clock);
      while (req_idle_enable && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_channel     <= s.channel;
      req_level       <= s.level;
      req_read_failed <= s.read_failed;
      req_time_ms     <= s.time_ms;
      req_prime       <= s.prime;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(debounce_step(s));
      request_count++;
   endtask

   // Stop offering and let every outstanding response drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four registers; block must be idle
   task automatic set_config(input logic [3:0] count, input logic [7:0] debounce,
                             input logic [63:0] keys, input logic [47:0] pins);
      logic [1:0]  idx  [4];
      logic [63:0] vals [4];
      idx  = '{CSR_CHANNEL_COUNT, CSR_DEBOUNCE_MS, CSR_KEY_CODE_TABLE, CSR_PIN_TABLE};
      vals = '{{60'd0, count}, {56'd0, debounce}, keys, {16'd0, pins}};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= idx[i];
         csr_wdata        <= vals[i];
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      key_cfg = '{count, debounce, keys, pins};
      setting_count++;
   endtask

   // Reset configuration has no channels: everything is ignored
   task automatic test_ignored_after_reset();
      send_sample(3'd0, 1'b0, 1'b1, 32'd10, 1'b0);
      send_sample(3'd7, 1'b0, 1'b0, 32'd20, 1'b0);
      send_sample(3'd3, 1'b0, 1'b0, 32'd30, 1'b1);
      wait_idle();
   endtask

   // Debounce boundary, time wrap, failed reads, prime, bounce
   task automatic test_debounce_edges();
      set_config(4'd8, 8'd25, 64'hFF01_2345_6789_AB00, 48'hFC00_0000_003F);
      send_sample(3'd0, 1'b0, 1'b0, 32'd5, 1'b1);           // prime as pressed
      send_sample(3'd0, 1'b1, 1'b0, 32'd100, 1'b0);         // raw change
      send_sample(3'd0, 1'b1, 1'b0, 32'd124, 1'b0);         // one short
      send_sample(3'd0, 1'b1, 1'b0, 32'd125, 1'b0);         // release event
      send_sample(3'd7, 1'b0, 1'b0, 32'hFFFF_FFF0, 1'b0);
      send_sample(3'd7, 1'b0, 1'b0, 32'h0000_0009, 1'b0);   // elapsed across wrap
      send_sample(3'd3, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);   // failed prime
      send_sample(3'd3, 1'b1, 1'b1, 32'd0, 1'b0);
      send_sample(3'd5, 1'b0, 1'b0, 32'd0, 1'b0);
      send_sample(3'd5, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);   // longest hold
      send_sample(3'd0, 1'b0, 1'b0, 32'd200, 1'b0);         // bounce back to
      send_sample(3'd0, 1'b1, 1'b0, 32'd210, 1'b0);         // the stable level
      send_sample(3'd0, 1'b1, 1'b0, 32'd300, 1'b0);
      wait_idle();
   endtask

   // Channel count above the channel limit, zero debounce
   task automatic test_zero_debounce();
      set_config(4'd15, 8'd0, 64'd0, 48'd0);
      send_sample(3'd6, 1'b0, 1'b0, 32'd50, 1'b0);
      send_sample(3'd6, 1'b0, 1'b0, 32'd50, 1'b0);          // second same sample
      send_sample(3'd6, 1'b1, 1'b0, 32'd51, 1'b0);
      send_sample(3'd6, 1'b1, 1'b0, 32'd51, 1'b0);
      wait_idle();
   endtask

   // Narrow channel count, longest debounce
   task automatic test_narrow_count();
      set_config(4'd3, 8'd255, {$urandom(), $urandom()}, 48'({$urandom(), $urandom()}));
      send_sample(3'd3, 1'b0, 1'b1, 32'd900, 1'b0);         // unused channel
      send_sample(3'd2, 1'b0, 1'b0, 32'd1000, 1'b0);
      send_sample(3'd2, 1'b0, 1'b0, 32'd1254, 1'b0);
      send_sample(3'd2, 1'b0, 1'b0, 32'd1255, 1'b0);
      send_sample(3'd7, 1'b0, 1'b0, 32'd1300, 1'b1);        // unused channel
      wait_idle();
   endtask

   // Mostly held levels with bounce, some failures, primes and time jumps
   task automatic run_random_phase(input int items, input logic [3:0] count,
                                   input logic [7:0] debounce, input logic [63:0] keys,
                                   input logic [47:0] pins);
      int unsigned active;
      int unsigned step_max;
      logic [2:0]  ch;
      logic        level;
      set_config(count, debounce, keys, pins);
      active = (count > KEY_CHANNELS) ? KEY_CHANNELS : count;
      step_max = debounce / 4 + 2;
      for (int i = 0; i < items; i++) begin
         if (active == 0 || $urandom_range(0, 9) == 0) begin
            ch = 3'($urandom_range(0, 7));
         end else begin
            ch = 3'($urandom_range(0, active - 1));
         end
         if ($urandom_range(0, 19) == 0) key_target[ch] = ~key_target[ch];
         level = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : key_target[ch];
         if ($urandom_range(0, 49) == 0) begin
            now_ms = $urandom();
         end else begin
            now_ms = now_ms + $urandom_range(0, step_max);
         end
         send_sample(ch, level, $urandom_range(0, 29) == 0, now_ms,
                     $urandom_range(0, 39) == 0);
      end
      wait_idle();
   endtask

   task automatic test_random_traffic();
      run_random_phase(300, 4'd8, 8'd25, {$urandom(), $urandom()},
                       48'({$urandom(), $urandom()}));
      run_random_phase(150, 4'd1, 8'd255, 64'd0, 48'd0);
      // no idling on either side for a long stretch
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      run_random_phase(250, 4'($urandom_range(2, 7)), 8'($urandom_range(1, 254)),
                       {$urandom(), $urandom()}, 48'({$urandom(), $urandom()}));
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
      run_random_phase(50, 4'd0, 8'd25, {$urandom(), $urandom()},
                       48'({$urandom(), $urandom()}));
      run_random_phase(450, 4'd8, 8'($urandom()), {$urandom(), $urandom()},
                       48'({$urandom(), $urandom()}));
   endtask

   // Response side held off while requests keep coming, time starts near the top of its range
   task automatic test_output_holdoff();
      now_ms = 32'hFFFF_0000;
      hold_start = cycle_count;
      hold_len = 300;
      run_random_phase(250, 4'd15, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_after_reset();
      test_debounce_edges();
      test_zero_debounce();
      test_narrow_count();
      test_output_holdoff();
      test_random_traffic();

      wait_idle();
      $display("Covered %0d requests over %0d register settings in %0d cycles",
               request_count, setting_count, cycle_count);
      $display("Checked %0d responses, %0d of them debounced key events",
               response_count, event_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/mkde_pkg.sv
hdl/mkde_track.sv
hdl/multi_key_debounce_event_core.sv
tb/sv/multi_key_debounce_event_core_tb.sv
